// ===== rtl/grp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grp_pkg
// Shared widths, codes and types of the guillotine rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

    localparam int MAX_SPACES_DEF = 64;
    localparam int COORD_BITS_DEF = 14;

    localparam int SIDE_W   = 14;
    localparam int EXP_W    = 8;
    localparam int PAD_W    = 10;
    localparam int SIZE_W   = 15;
    localparam int OUT_W    = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_SIDE  = 2'd0,
        CFG_EDGE_EXPAND = 2'd1,
        CFG_GAP_BORDER  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_PERFECT = 2'd0,
        K_RIGHT   = 2'd1,
        K_DOWN    = 2'd2,
        K_SPLIT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_fit_ctl;

endpackage

// ===== rtl/grp_space_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grp_space_ram
// Free-space table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grp_space_ram import grp_pkg::*; #(
    parameter int MAX_SPACES = MAX_SPACES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_SPACES)-1:0] i_waddr,
    input  logic [4*COORD_BITS-1:0]       i_wdata,
    input  logic [$clog2(MAX_SPACES)-1:0] i_raddr,
    output logic [4*COORD_BITS-1:0]       o_rdata
);

    logic [4*COORD_BITS-1:0] r_mem [MAX_SPACES];
    logic [4*COORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/grp_fit_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grp_fit_eval
// Fit test of one free space and the guillotine update words for it.
// ----------------------------------------------------------------------------
module grp_fit_eval import grp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [4*COORD_BITS-1:0] i_entry,
    input  logic [SIZE_W-1:0]       i_w,
    input  logic [SIZE_W-1:0]       i_h,
    input  logic [EXP_W-1:0]        i_expand,
    output t_fit_ctl                o_ctl,
    output logic [4*COORD_BITS-1:0] o_upd_word,
    output logic [4*COORD_BITS-1:0] o_app_word,
    output logic [OUT_W-1:0]        o_px,
    output logic [OUT_W-1:0]        o_py
);

    localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

    logic [COORD_BITS-1:0] sx, sy, sw, sh;
    logic [COORD_BITS-1:0] w_c, h_c, nx, ny, nw, nh;
    logic [CMP_W-1:0]      w_e, h_e, sw_e, sh_e;
    logic                  eq_w, eq_h;

    assign {sx, sy, sw, sh} = i_entry;

    assign w_e  = CMP_W'(i_w);
    assign h_e  = CMP_W'(i_h);
    assign sw_e = CMP_W'(sw);
    assign sh_e = CMP_W'(sh);
    assign eq_w = (w_e == sw_e);
    assign eq_h = (h_e == sh_e);

    assign w_c = COORD_BITS'(i_w);
    assign h_c = COORD_BITS'(i_h);
    assign nx  = sx + w_c;
    assign nw  = sw - w_c;
    assign ny  = sy + h_c;
    assign nh  = sh - h_c;

    always_comb begin
        o_ctl.hit = (w_e <= sw_e) && (h_e <= sh_e);
        if (eq_w && eq_h) begin
            o_ctl.kind = K_PERFECT;
        end else if (eq_h) begin
            o_ctl.kind = K_RIGHT;
        end else if (eq_w) begin
            o_ctl.kind = K_DOWN;
        end else begin
            o_ctl.kind = K_SPLIT;
        end
    end

    assign o_upd_word = (o_ctl.kind == K_RIGHT) ? {nx, sy, nw, sh} : {sx, ny, sw, nh};
    assign o_app_word = {nx, sy, nw, h_c};

    assign o_px = OUT_W'(sx) + OUT_W'(i_expand);
    assign o_py = OUT_W'(sy) + OUT_W'(i_expand);

endmodule

// ===== rtl/guillotine_rect_packer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guillotine_rect_packer_core
// Places rectangles in a square atlas from a table of free spaces.
// Free spaces are scanned newest first, one table read per cycle, at most
//   MAX_SPACES of them; a hit may rewrite a space, a split also append one. An
//   oversize rectangle or an empty table reports in the next cycle.
// Throughput: one item at a time; busy drops in the cycle o_done is high.
// Reset: table holds one full 4096 atlas space, registers at reset values.
// o_done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_core import grp_pkg::*; #(
    parameter int MAX_SPACES = MAX_SPACES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [SIDE_W-1:0]     i_rect_width,
    input  logic [SIDE_W-1:0]     i_rect_height,
    input  logic                  i_start_set,
    output logic                  o_done,
    output logic [OUT_W-1:0]      o_pos_x,
    output logic [OUT_W-1:0]      o_pos_y,
    output logic [1:0]            o_place_status
);

    localparam int IDX_W  = $clog2(MAX_SPACES);
    localparam int CNT_W  = $clog2(MAX_SPACES + 1);
    localparam int WORD_W = 4 * COORD_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MOVE = 5'b00100,
        S_UPD  = 5'b01000,
        S_APP  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic                  r_e0_fresh;
    logic [COORD_BITS-1:0] r_e0_side;
    logic [SIDE_W-1:0]     r_atlas;
    logic [EXP_W-1:0]      r_expand;
    logic [EXP_W-1:0]      r_border;
    logic                  r_done, n_done;

    logic [SIZE_W-1:0]     r_w, r_h;
    logic [IDX_W-1:0]      r_idx, r_hs;
    t_kind                 r_kind;
    logic [WORD_W-1:0]     r_upd_word, r_app_word;
    logic [OUT_W-1:0]      r_px, r_py;
    t_status               r_stat;

    logic                  acc, early_miss, move_needed, room;
    logic [PAD_W-1:0]      pad;
    logic [SIZE_W-1:0]     w_in, h_in;
    logic [CNT_W-1:0]      eff_cnt, eff_m1, cnt_m1;
    logic [IDX_W-1:0]      last_idx;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata, entry;

    t_fit_ctl              fit_ctl;
    logic [WORD_W-1:0]     fit_upd, fit_app;
    logic [OUT_W-1:0]      fit_px, fit_py;

    assign busy = (r_state != S_IDLE);
    assign acc  = start && !busy;

    assign pad  = PAD_W'({r_expand, 1'b0}) + PAD_W'(r_border);
    assign w_in = SIZE_W'(i_rect_width) + SIZE_W'(pad);
    assign h_in = SIZE_W'(i_rect_height) + SIZE_W'(pad);

    assign eff_cnt    = i_start_set ? CNT_W'(1) : r_count;
    assign eff_m1     = eff_cnt - CNT_W'(1);
    assign early_miss = (w_in > SIZE_W'(r_atlas)) || (h_in > SIZE_W'(r_atlas))
                        || (eff_cnt == '0);

    assign cnt_m1      = r_count - CNT_W'(1);
    assign last_idx    = cnt_m1[IDX_W-1:0];
    assign move_needed = (r_idx != last_idx);
    assign room        = (r_count < CNT_W'(MAX_SPACES));

    assign entry = (r_idx == '0 && r_e0_fresh)
                   ? {{COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}, r_e0_side, r_e0_side}
                   : ram_rdata;

    grp_space_ram #(
        .MAX_SPACES(MAX_SPACES),
        .COORD_BITS(COORD_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    grp_fit_eval #(
        .COORD_BITS(COORD_BITS)
    ) u_fit (
        .i_entry   (entry),
        .i_w       (r_w),
        .i_h       (r_h),
        .i_expand  (r_expand),
        .o_ctl     (fit_ctl),
        .o_upd_word(fit_upd),
        .o_app_word(fit_app),
        .o_px      (fit_px),
        .o_py      (fit_py)
    );

    always_comb begin
        ram_raddr = r_idx - IDX_W'(1);
        if (r_state == S_IDLE) begin
            ram_raddr = eff_m1[IDX_W-1:0];
        end else if (r_state == S_SCAN && fit_ctl.hit && fit_ctl.kind == K_PERFECT) begin
            ram_raddr = last_idx;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hs;
        ram_wdata = r_upd_word;
        case (r_state)
            S_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_UPD: begin
                ram_we = 1'b1;
            end
            S_APP: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[IDX_W-1:0];
                ram_wdata = r_app_word;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (early_miss) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (fit_ctl.hit) begin
                    if (fit_ctl.kind == K_PERFECT) begin
                        if (move_needed) begin
                            n_state = S_MOVE;
                        end else begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end
                    end else begin
                        n_state = S_UPD;
                    end
                end else if (r_idx == '0) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_UPD: begin
                if (r_kind == K_SPLIT && room) begin
                    n_state = S_APP;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_MOVE, S_APP: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= CNT_W'(1);
            r_e0_fresh <= 1'b1;
            r_e0_side  <= COORD_BITS'(RESET_SIDE);
            r_atlas    <= RESET_SIDE;
            r_expand   <= '0;
            r_border   <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ATLAS_SIDE:  r_atlas  <= i_cfg_wdata;
                    CFG_EDGE_EXPAND: r_expand <= i_cfg_wdata[EXP_W-1:0];
                    CFG_GAP_BORDER:  r_border <= i_cfg_wdata[EXP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (ram_we && ram_waddr == '0) begin
                r_e0_fresh <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc && i_start_set) begin
                        r_count    <= CNT_W'(1);
                        r_e0_fresh <= 1'b1;
                        r_e0_side  <= COORD_BITS'(r_atlas);
                    end
                end
                S_SCAN: begin
                    if (fit_ctl.hit && fit_ctl.kind == K_PERFECT) begin
                        r_count <= cnt_m1;
                    end
                end
                S_APP: begin
                    r_count <= r_count + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    r_w   <= w_in;
                    r_h   <= h_in;
                    r_idx <= eff_m1[IDX_W-1:0];
                    r_px  <= '0;
                    r_py  <= '0;
                    r_stat <= ST_NO_FIT;
                end
            end
            S_SCAN: begin
                if (fit_ctl.hit) begin
                    r_hs       <= r_idx;
                    r_kind     <= fit_ctl.kind;
                    r_upd_word <= fit_upd;
                    r_app_word <= fit_app;
                    r_px       <= fit_px;
                    r_py       <= fit_py;
                    r_stat     <= (fit_ctl.kind == K_SPLIT && !room) ? ST_DROPPED : ST_PLACED;
                end else begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_pos_x        = r_px;
    assign o_pos_y        = r_py;
    assign o_place_status = r_stat;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPACES))
        else $error("free count above table depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("scan index outside valid entries");

    a_app_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APP) |-> room)
        else $error("append into full table");

    a_e0_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_waddr == '0) |=> !r_e0_fresh)
        else $error("entry zero override survives a write");

endmodule
